// ----- rtl/gfm_pkg.sv -----
`timescale 1ns / 1ps
// gfm_pkg: shared types and constants for the GF(2^n) multiply/square block
// no dependencies

package gfm_pkg;

	localparam int WORD_BITS  = 64;
	localparam int DIGIT_BITS = 8;
	localparam int RED_W      = 11;

	// low terms of the field polynomial, the x^n term left out
	localparam logic [RED_W-1:0] RED_LOW_STD = 11'h087; // x^7+x^2+x+1
	localparam logic [RED_W-1:0] RED_LOW_256 = 11'h425; // x^10+x^5+x^2+1

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_START = 4'b0010,
		ST_MUL   = 4'b0100,
		ST_OUT   = 4'b1000
	} gfm_state_t;

	typedef struct packed {
		logic start;
		logic step;
		logic shift_out;
		logic square;
	} gfm_mult_ctrl_t;

endpackage

// ----- rtl/gf2n_multiply_square_top.sv -----
`timescale 1ns / 1ps
// gf2n_multiply_square_top: GF(2^n) multiply/square, n = 128, 192 or 256
// depends on gfm_pkg, gfm_operand_store, gfm_digit_mult
//
// usage:
//   operand channel (op_valid/op_ready): one beat carries one word of a and
//   one of b, least significant first; last_in marks the final beat, whose
//   op bit picks multiply (0) or square of a (1). missing words read as zero,
//   words beyond n/64 are dropped.
//   result channel (res_valid/res_ready): n/64 beats of c_word, least
//   significant first, last_out on the most significant word.
// sequence:
//   the load takes beats while op_ready is high; after the last beat, the setup
//   state and the digit steps (one 8-bit digit of b, or of a when squaring,
//   per cycle through the multiplier) pass before the first result word
//   shows, then one word per cycle while the receiver takes them.
//   op_ready is high only while loading; it stays low until the last result
//   word is taken.
// reset: asynchronous, clears the operand words, the load count and the
//   control; a stalled receiver just holds the current result word.

module gf2n_multiply_square_top import gfm_pkg::*; #(
	parameter int FIELD_BITS = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 op_valid,
	output logic                 op_ready,
	input  logic                 op,
	input  logic [WORD_BITS-1:0] a_word,
	input  logic [WORD_BITS-1:0] b_word,
	input  logic                 last_in,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [WORD_BITS-1:0] c_word,
	output logic                 last_out
);

	localparam int NW     = (FIELD_BITS >= 256) ? 4 : ((FIELD_BITS >= 192) ? 3 : 2);
	localparam int DIGITS = NW * WORD_BITS / DIGIT_BITS;
	localparam int DCW    = $clog2(DIGITS);
	localparam int WCW    = $clog2(NW);
	localparam logic [DCW-1:0] DCNT_LAST = DCW'(DIGITS - 1);
	localparam logic [WCW-1:0] WCNT_LAST = WCW'(NW - 1);

	gfm_state_t          state_q;
	logic                sq_q;
	logic [DCW-1:0]      dcnt_q;
	logic [WCW-1:0]      wcnt_q;
	logic                op_beat;
	logic                res_beat;
	logic                mul_done;
	gfm_mult_ctrl_t      mctrl;
	logic [NW*WORD_BITS-1:0] a_vec;
	logic [NW*WORD_BITS-1:0] b_vec;

	assign op_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_OUT);
	assign last_out  = (wcnt_q == WCNT_LAST);
	assign op_beat   = op_valid && op_ready;
	assign res_beat  = res_valid && res_ready;
	assign mul_done  = (state_q == ST_MUL) && (dcnt_q == DCNT_LAST);

	assign mctrl.start     = (state_q == ST_START);
	assign mctrl.step      = (state_q == ST_MUL);
	assign mctrl.shift_out = res_beat;
	assign mctrl.square    = sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sq_q    <= 1'b0;
			dcnt_q  <= '0;
			wcnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (op_beat && last_in) begin
						sq_q    <= op;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					dcnt_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (mul_done) begin
						wcnt_q  <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (res_beat) begin
						wcnt_q <= wcnt_q + 1'b1;
						if (last_out) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// operands are no longer needed once the last digit is in
	gfm_operand_store #(
		.NW(NW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (op_beat),
		.clear  (mul_done),
		.a_word (a_word),
		.b_word (b_word),
		.a_vec  (a_vec),
		.b_vec  (b_vec)
	);

	gfm_digit_mult #(
		.NW(NW)
	) u_mult (
		.clk    (clk),
		.ctrl   (mctrl),
		.a_vec  (a_vec),
		.b_vec  (b_vec),
		.c_word (c_word)
	);

endmodule

// ----- rtl/gfm_operand_store.sv -----
`timescale 1ns / 1ps
// gfm_operand_store: operand word registers for a and b plus the load count
// depends on gfm_pkg

module gfm_operand_store import gfm_pkg::*; #(
	parameter int NW = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic                    clear,
	input  logic [WORD_BITS-1:0]    a_word,
	input  logic [WORD_BITS-1:0]    b_word,
	output logic [NW*WORD_BITS-1:0] a_vec,
	output logic [NW*WORD_BITS-1:0] b_vec
);

	localparam int CW = $clog2(NW + 1);
	localparam int IW = $clog2(NW);
	localparam logic [CW-1:0] CNT_FULL = CW'(NW);

	logic [CW-1:0]        cnt_q;
	logic [WORD_BITS-1:0] a_q [NW];
	logic [WORD_BITS-1:0] b_q [NW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < NW; i++) begin
				a_q[i] <= '0;
				b_q[i] <= '0;
			end
		end else if (clear) begin
			cnt_q <= '0;
			for (int i = 0; i < NW; i++) begin
				a_q[i] <= '0;
				b_q[i] <= '0;
			end
		end else if (wr_en && (cnt_q != CNT_FULL)) begin
			// words past the field width are dropped
			a_q[cnt_q[IW-1:0]] <= a_word;
			b_q[cnt_q[IW-1:0]] <= b_word;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	for (genvar g = 0; g < NW; g++) begin : g_flat
		assign a_vec[g*WORD_BITS +: WORD_BITS] = a_q[g];
		assign b_vec[g*WORD_BITS +: WORD_BITS] = b_q[g];
	end

endmodule

// ----- rtl/gfm_digit_mult.sv -----
`timescale 1ns / 1ps
// gfm_digit_mult: msb-first digit-serial multiplier with interleaved reduction
// and word-wise result shift-out; depends on gfm_pkg

module gfm_digit_mult import gfm_pkg::*; #(
	parameter int NW = 2
) (
	input  logic                    clk,
	input  gfm_mult_ctrl_t          ctrl,
	input  logic [NW*WORD_BITS-1:0] a_vec,
	input  logic [NW*WORD_BITS-1:0] b_vec,
	output logic [WORD_BITS-1:0]    c_word
);

	localparam int N = NW * WORD_BITS;
	localparam int D = DIGIT_BITS;
	localparam logic [RED_W-1:0] RED = (NW == 4) ? RED_LOW_256 : RED_LOW_STD;

	logic [N-1:0]   acc_q;
	logic [N-1:0]   bsh_q;
	logic [D-1:0]   dig;
	logic [N+D-1:0] wide;
	logic [N-1:0]   fold;
	logic [N-1:0]   acc_next;

	assign dig = bsh_q[N-1 -: D];

	// acc*x^D + a*digit, then fold the D overflow bits back with the low terms
	always_comb begin
		wide = {acc_q, {D{1'b0}}};
		for (int k = 0; k < D; k++) begin
			if (dig[k]) begin
				wide = wide ^ ({{D{1'b0}}, a_vec} << k);
			end
		end
		fold = '0;
		for (int k = 0; k < D; k++) begin
			if (wide[N+k]) begin
				fold = fold ^ ({{(N-RED_W){1'b0}}, RED} << k);
			end
		end
		acc_next = wide[N-1:0] ^ fold;
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			acc_q <= '0;
			bsh_q <= ctrl.square ? a_vec : b_vec;
		end else if (ctrl.step) begin
			acc_q <= acc_next;
			bsh_q <= bsh_q << D;
		end else if (ctrl.shift_out) begin
			acc_q <= acc_q >> WORD_BITS;
		end
	end

	assign c_word = acc_q[WORD_BITS-1:0];

endmodule

// ----- rtl/gfm_checker.sv -----
`timescale 1ns / 1ps
// gfm_checker: port-level checks for gf2n_multiply_square_top, with its bind
// depends on gfm_pkg

module gfm_checker import gfm_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 op_valid,
	input logic                 op_ready,
	input logic                 last_in,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic [WORD_BITS-1:0] c_word,
	input logic                 last_out
);

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(c_word) && $stable(last_out))
		else $error("result beat changed while stalled");

	// loading and result delivery never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(op_ready && res_valid))
		else $error("operand and result channels open together");

	// the final operand beat closes the operand channel and no result shows yet
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && op_ready && last_in |=> !op_ready && !res_valid)
		else $error("block still open after final operand beat");

	// taking the final result word reopens the operand channel
	a_last_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && last_out |=> op_ready && !res_valid)
		else $error("block not idle after final result beat");

endmodule

bind gf2n_multiply_square_top gfm_checker u_gfm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.op_valid  (op_valid),
	.op_ready  (op_ready),
	.last_in   (last_in),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.c_word    (c_word),
	.last_out  (last_out)
);
